>>> sv/assert_macros.svh
// Assertion macros shared by the touch and sound register block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TACRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define TACRB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> sv/tacrb_pkg.sv
// Types, codes and constants of the touch and sound register block.
package tacrb_pkg;

  localparam int unsigned CODEC_REGS = 16;
  localparam int unsigned CODEC_IDX_W = $clog2(CODEC_REGS);

  // Request modes.
  localparam logic [2:0] MODE_READ  = 3'd0;
  localparam logic [2:0] MODE_WRITE = 3'd1;
  localparam logic [2:0] MODE_DOWN  = 3'd2;
  localparam logic [2:0] MODE_MOVE  = 3'd3;
  localparam logic [2:0] MODE_UP    = 3'd4;
  localparam logic [2:0] MODE_TICK  = 3'd5;
  localparam logic [2:0] MODE_RAISE = 3'd6;

  // Register offsets.
  localparam logic [7:0] OFF_ADC_CTRL   = 8'h00;
  localparam logic [7:0] OFF_ADC_STAT   = 8'h04;
  localparam logic [7:0] OFF_CODEC_CTRL = 8'h08;
  localparam logic [7:0] OFF_CODEC_STAT = 8'h0C;
  localparam logic [7:0] OFF_CODEC_DATA = 8'h10;
  localparam logic [7:0] OFF_SOUND_CTRL = 8'h14;
  localparam logic [7:0] OFF_SOUND_STAT = 8'h18;
  localparam logic [7:0] OFF_IRQ_MASK   = 8'h1C;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEN_PERIOD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COORD_SCALE = 1'b1;
  localparam logic [15:0] PEN_PERIOD_RST  = 16'd5;
  localparam logic [4:0]  COORD_SCALE_RST = 5'd4;

  // Bit masks.
  localparam logic [15:0] SAMPLE_MASK   = 16'h0FFF;
  localparam logic [15:0] CAL_DONE_BITS = 16'h0C00;
  localparam logic [15:0] PEN_UP_BIT    = 16'h1000;
  localparam logic [15:0] DO_SAMPLE     = 16'h4000;
  localparam logic [15:0] SEL_Y         = 16'h0800;
  localparam logic [15:0] TIMING_EN     = 16'h0400;
  localparam logic [15:0] CODEC_WR      = 16'h0010;
  localparam logic [15:0] PLAY_EN       = 16'h4000;
  localparam logic [15:0] ADC_CLR       = 16'h001C;
  localparam logic [15:0] CODEC_CLR     = 16'h0001;
  localparam logic [15:0] SOUND_CLR     = 16'hF000;
  localparam logic [15:0] ADC_PEN_BIT   = 16'h0010;
  localparam logic [15:0] ADC_DOWN_BIT  = 16'h0008;
  localparam logic [15:0] ADC_TIME_BIT  = 16'h0004;
  localparam logic [15:0] CODEC_DONE    = 16'h0001;
  localparam logic [15:0] MASK_SOUND    = 16'h0002;

  localparam logic [CODEC_IDX_W-1:0] CODEC_IDX_PEN = CODEC_IDX_W'(9);
  localparam logic [CODEC_IDX_W-1:0] CODEC_IDX_CAL = CODEC_IDX_W'(10);

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         reg_offset;
    logic [31:0]        write_data;
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;
    logic [15:0]        raise_bits;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq;
    logic        fault;
    logic        playback_enable;
    logic        playback_changed;
    logic        sound_already_set;
  } result_t;

  typedef struct packed {
    logic                   we;
    logic [CODEC_IDX_W-1:0] addr;
    logic [15:0]            data;
  } ram_wr_t;

endpackage

>>> sv/tacrb_ifs.sv
// Request and result channel interfaces of the touch and sound register block.
interface tacrb_item_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic [7:0]         reg_offset;
  logic [31:0]        write_data;
  logic signed [15:0] pen_x;
  logic signed [15:0] pen_y;
  logic [15:0]        raise_bits;

  modport source (output valid, mode, reg_offset, write_data, pen_x, pen_y, raise_bits,
                  input ready);
  modport sink (input valid, mode, reg_offset, write_data, pen_x, pen_y, raise_bits,
                output ready);
endinterface

interface tacrb_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        irq;
  logic        fault;
  logic        playback_enable;
  logic        playback_changed;
  logic        sound_already_set;

  modport source (output valid, read_data, irq, fault, playback_enable, playback_changed,
                  sound_already_set, input ready);
  modport sink (input valid, read_data, irq, fault, playback_enable, playback_changed,
                sound_already_set, output ready);
endinterface

>>> sv/touch_audio_codec_register_block.sv
// Touch and sound controller register block: eight 16-bit bus registers, pen events, timer
// ticks and sound-status raises, one result per request. In the accept cycle the codec
// register file entry selected by codec control is read from its RAM; in the execute state,
// once the output register is free or being emptied, the registers are updated and the
// result enters the output register. A new request is accepted only back in idle, so the
// block takes no request before it is through with the last. A waiting result does not
// block the next request, only the completion of the one after it. The register file needs
// no clearing pass after reset: a per-entry valid bit makes unwritten entries read as zero.
// Configuration writes go to the pen timing period (index 0) and the coordinate scale
// (index 1) and must arrive while no request is in flight.
`include "assert_macros.svh"

module touch_audio_codec_register_block (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tacrb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  tacrb_item_if.sink                      item_i,
  tacrb_result_if.source                  result_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                                 state_q, state_d;
  tacrb_pkg::item_t                     item_q;
  tacrb_pkg::item_t                     item_in;
  tacrb_pkg::result_t                   result_q, result;
  tacrb_pkg::ram_wr_t                   ram_wr;
  logic                                 out_valid_q, out_valid_d;
  logic                                 item_acc;
  logic                                 fire;
  logic [tacrb_pkg::CODEC_REGS-1:0]     entry_vld_q;
  logic                                 entry_hit_q;
  logic [tacrb_pkg::CODEC_IDX_W-1:0]    entry_idx;
  logic [15:0]                          ram_rdata;
  logic [15:0]                          entry_word;

  assign item_in = '{mode: item_i.mode, reg_offset: item_i.reg_offset,
                     write_data: item_i.write_data, pen_x: item_i.pen_x,
                     pen_y: item_i.pen_y, raise_bits: item_i.raise_bits};

  assign item_i.ready = (state_q == S_IDLE);
  assign item_acc = item_i.valid && item_i.ready;
  // The request completes once the output register is free or being emptied.
  assign fire = (state_q == S_EXEC) && (!out_valid_q || result_o.ready);

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (item_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      entry_vld_q <= '0;
      entry_hit_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (ram_wr.we) begin
        entry_vld_q[ram_wr.addr] <= 1'b1;
      end
      if (item_acc) begin
        entry_hit_q <= entry_vld_q[entry_idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      item_q <= item_in;
    end
    if (fire) begin
      result_q <= result;
    end
  end

  tacrb_ram #(
    .WIDTH (16),
    .DEPTH (tacrb_pkg::CODEC_REGS)
  ) u_codec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (item_acc),
    .raddr_i (entry_idx),
    .rdata_o (ram_rdata)
  );

  assign entry_word = entry_hit_q ? ram_rdata : 16'd0;

  tacrb_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (fire),
    .item_i      (item_q),
    .entry_i     (entry_word),
    .entry_idx_o (entry_idx),
    .ram_wr_o    (ram_wr),
    .result_o    (result)
  );

  assign result_o.valid             = out_valid_q;
  assign result_o.read_data         = result_q.read_data;
  assign result_o.irq               = result_q.irq;
  assign result_o.fault             = result_q.fault;
  assign result_o.playback_enable   = result_q.playback_enable;
  assign result_o.playback_changed  = result_q.playback_changed;
  assign result_o.sound_already_set = result_q.sound_already_set;

  `TACRB_ASSERT(a_busy_blocks_input, (state_q == S_EXEC) |-> !item_i.ready, "input open while busy")
  `TACRB_ASSERT_NEXT(a_accept_executes, item_acc, state_q == S_EXEC, "accepted request not run")
  `TACRB_ASSERT(a_fire_has_room, fire |-> (!out_valid_q || result_o.ready), "result overwritten")
  `TACRB_ASSERT(a_ram_write_on_fire, ram_wr.we |-> fire, "codec RAM written outside execution")
  `TACRB_ASSERT(a_fault_excl_toggle, out_valid_q |-> !(result_q.fault && result_q.playback_changed), "faulted write toggled playback")

endmodule

>>> sv/tacrb_ram.sv
// Generic single-port-write, registered-read RAM.
module tacrb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tacrb_exec.sv
// Register state and per-request update logic of the touch and sound register block.
module tacrb_exec (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [tacrb_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [15:0]                              cfg_data_i,
  input  logic                                     fire_i,
  input  tacrb_pkg::item_t                         item_i,
  input  logic [15:0]                              entry_i,
  output logic [tacrb_pkg::CODEC_IDX_W-1:0]        entry_idx_o,
  output tacrb_pkg::ram_wr_t                       ram_wr_o,
  output tacrb_pkg::result_t                       result_o
);

  localparam int unsigned CODEC_IDX_W_LOCAL = tacrb_pkg::CODEC_IDX_W;

  logic [15:0] pen_period_q;
  logic [4:0]  coord_scale_q;

  logic [15:0] adc_ctrl_q, adc_ctrl_d;
  logic [15:0] adc_stat_q, adc_stat_d;
  logic [15:0] codec_ctrl_q, codec_ctrl_d;
  logic [15:0] codec_stat_q, codec_stat_d;
  logic [15:0] codec_data_q, codec_data_d;
  logic [15:0] sound_ctrl_q, sound_ctrl_d;
  logic [15:0] sound_stat_q, sound_stat_d;
  logic [15:0] irq_mask_q, irq_mask_d;
  logic [11:0] sample_x_q, sample_x_d;
  logic [11:0] sample_y_q, sample_y_d;
  logic        pen_down_q, pen_down_d;
  logic [15:0] tick_q, tick_d;
  logic        timing_en_q, timing_en_d;

  logic [11:0] raw_x, raw_y;
  logic [15:0] wval;
  logic [15:0] entry_word;
  logic [16:0] tick_inc;
  logic [CODEC_IDX_W_LOCAL-1:0] idx;

  // Clamp at zero, scale, and saturate to the 12-bit sample range.
  function automatic logic [11:0] to_raw(logic signed [15:0] v, logic [4:0] scale);
    logic [19:0] prod;
    prod = 20'(v[14:0]) * 20'(scale);
    if (v[15]) begin
      return 12'd0;
    end else if (prod > 20'(tacrb_pkg::SAMPLE_MASK)) begin
      return tacrb_pkg::SAMPLE_MASK[11:0];
    end
    return prod[11:0];
  endfunction

  assign raw_x = to_raw(item_i.pen_x, coord_scale_q);
  assign raw_y = to_raw(item_i.pen_y, coord_scale_q);
  assign wval = item_i.write_data[15:0];
  assign idx = codec_ctrl_q[CODEC_IDX_W_LOCAL-1:0];
  assign entry_idx_o = idx;
  assign tick_inc = {1'b0, tick_q} + 17'd1;

  // Entry read through codec data, with the hardwired status bits folded in.
  always_comb begin
    entry_word = entry_i;
    if (idx == tacrb_pkg::CODEC_IDX_CAL) begin
      entry_word = entry_word | tacrb_pkg::CAL_DONE_BITS;
    end
    if (idx == tacrb_pkg::CODEC_IDX_PEN) begin
      entry_word = pen_down_q ? (entry_word & ~tacrb_pkg::PEN_UP_BIT)
                              : (entry_word | tacrb_pkg::PEN_UP_BIT);
    end
  end

  always_comb begin
    adc_ctrl_d   = adc_ctrl_q;
    adc_stat_d   = adc_stat_q;
    codec_ctrl_d = codec_ctrl_q;
    codec_stat_d = codec_stat_q;
    codec_data_d = codec_data_q;
    sound_ctrl_d = sound_ctrl_q;
    sound_stat_d = sound_stat_q;
    irq_mask_d   = irq_mask_q;
    sample_x_d   = sample_x_q;
    sample_y_d   = sample_y_q;
    pen_down_d   = pen_down_q;
    tick_d       = tick_q;
    timing_en_d  = timing_en_q;
    ram_wr_o     = '{we: 1'b0, addr: idx, data: wval};
    result_o     = '0;

    case (item_i.mode)
      tacrb_pkg::MODE_READ: begin
        case (item_i.reg_offset)
          tacrb_pkg::OFF_ADC_CTRL:   result_o.read_data = adc_ctrl_q;
          tacrb_pkg::OFF_ADC_STAT:   result_o.read_data = adc_stat_q;
          tacrb_pkg::OFF_CODEC_CTRL: result_o.read_data = codec_ctrl_q;
          tacrb_pkg::OFF_CODEC_STAT: result_o.read_data = codec_stat_q;
          tacrb_pkg::OFF_CODEC_DATA: result_o.read_data = codec_data_q;
          tacrb_pkg::OFF_SOUND_CTRL: result_o.read_data = sound_ctrl_q;
          tacrb_pkg::OFF_SOUND_STAT: result_o.read_data = sound_stat_q;
          tacrb_pkg::OFF_IRQ_MASK:   result_o.read_data = irq_mask_q;
          default:                   result_o.fault = 1'b1;
        endcase
      end
      tacrb_pkg::MODE_WRITE: begin
        if (item_i.write_data[31:16] != 16'd0) begin
          result_o.fault = 1'b1;
        end else begin
          case (item_i.reg_offset)
            tacrb_pkg::OFF_ADC_CTRL: begin
              adc_ctrl_d = wval;
              if ((wval & tacrb_pkg::DO_SAMPLE) != 16'd0) begin
                adc_ctrl_d = {wval[15:12],
                              ((wval & tacrb_pkg::SEL_Y) != 16'd0) ? sample_y_q : sample_x_q};
                adc_stat_d = adc_stat_q | tacrb_pkg::ADC_PEN_BIT;
              end
              timing_en_d = (wval & tacrb_pkg::TIMING_EN) != 16'd0;
              if (timing_en_d && !timing_en_q) begin
                tick_d = 16'd0;
              end
            end
            tacrb_pkg::OFF_ADC_STAT: begin
              if ((wval & ~tacrb_pkg::ADC_CLR) != 16'd0) begin
                result_o.fault = 1'b1;
              end else begin
                adc_stat_d = adc_stat_q & ~wval;
              end
            end
            tacrb_pkg::OFF_CODEC_CTRL: codec_ctrl_d = wval;
            tacrb_pkg::OFF_CODEC_STAT: begin
              if ((wval & ~tacrb_pkg::CODEC_CLR) != 16'd0) begin
                result_o.fault = 1'b1;
              end else begin
                codec_stat_d = codec_stat_q & ~wval;
              end
            end
            tacrb_pkg::OFF_CODEC_DATA: begin
              if ((codec_ctrl_q & tacrb_pkg::CODEC_WR) != 16'd0) begin
                ram_wr_o.we  = fire_i;
                codec_data_d = wval;
              end else begin
                codec_data_d = entry_word;
              end
              codec_stat_d = codec_stat_q | tacrb_pkg::CODEC_DONE;
            end
            tacrb_pkg::OFF_SOUND_CTRL: begin
              result_o.playback_changed = ((sound_ctrl_q ^ wval) & tacrb_pkg::PLAY_EN) != 16'd0;
              sound_ctrl_d = wval;
            end
            tacrb_pkg::OFF_SOUND_STAT: begin
              if ((wval & ~tacrb_pkg::SOUND_CLR) != 16'd0) begin
                result_o.fault = 1'b1;
              end else begin
                sound_stat_d = sound_stat_q & ~wval;
              end
            end
            tacrb_pkg::OFF_IRQ_MASK: irq_mask_d = wval;
            default: result_o.fault = 1'b1;
          endcase
        end
      end
      tacrb_pkg::MODE_DOWN: begin
        sample_x_d = raw_x;
        sample_y_d = raw_y;
        adc_stat_d = adc_stat_q | tacrb_pkg::ADC_DOWN_BIT;
        pen_down_d = 1'b1;
      end
      tacrb_pkg::MODE_MOVE: begin
        if (pen_down_q) begin
          sample_x_d = raw_x;
          sample_y_d = raw_y;
        end
      end
      tacrb_pkg::MODE_UP: pen_down_d = 1'b0;
      tacrb_pkg::MODE_TICK: begin
        if (timing_en_q) begin
          // A period of zero behaves as one since the increment is at least one.
          if (tick_inc >= {1'b0, pen_period_q}) begin
            tick_d     = 16'd0;
            adc_stat_d = adc_stat_q | tacrb_pkg::ADC_TIME_BIT;
          end else begin
            tick_d = tick_inc[15:0];
          end
        end
      end
      tacrb_pkg::MODE_RAISE: begin
        result_o.sound_already_set = (sound_stat_q & item_i.raise_bits) != 16'd0;
        sound_stat_d = sound_stat_q | item_i.raise_bits;
      end
      default: ;
    endcase

    result_o.irq = ((adc_stat_d & irq_mask_d & tacrb_pkg::ADC_CLR) != 16'd0)
                || ((codec_stat_d & irq_mask_d & tacrb_pkg::CODEC_CLR) != 16'd0)
                || (((irq_mask_d & tacrb_pkg::MASK_SOUND) != 16'd0)
                    && ((sound_stat_d & tacrb_pkg::SOUND_CLR) != 16'd0));
    result_o.playback_enable = (sound_ctrl_d & tacrb_pkg::PLAY_EN) != 16'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_period_q  <= tacrb_pkg::PEN_PERIOD_RST;
      coord_scale_q <= tacrb_pkg::COORD_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tacrb_pkg::CFG_PEN_PERIOD:  pen_period_q  <= cfg_data_i;
        tacrb_pkg::CFG_COORD_SCALE: coord_scale_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_ctrl_q   <= '0;
      adc_stat_q   <= '0;
      codec_ctrl_q <= '0;
      codec_stat_q <= '0;
      codec_data_q <= '0;
      sound_ctrl_q <= '0;
      sound_stat_q <= '0;
      irq_mask_q   <= '0;
      sample_x_q   <= '0;
      sample_y_q   <= '0;
      pen_down_q   <= 1'b0;
      tick_q       <= '0;
      timing_en_q  <= 1'b0;
    end else if (fire_i) begin
      adc_ctrl_q   <= adc_ctrl_d;
      adc_stat_q   <= adc_stat_d;
      codec_ctrl_q <= codec_ctrl_d;
      codec_stat_q <= codec_stat_d;
      codec_data_q <= codec_data_d;
      sound_ctrl_q <= sound_ctrl_d;
      sound_stat_q <= sound_stat_d;
      irq_mask_q   <= irq_mask_d;
      sample_x_q   <= sample_x_d;
      sample_y_q   <= sample_y_d;
      pen_down_q   <= pen_down_d;
      tick_q       <= tick_d;
      timing_en_q  <= timing_en_d;
    end
  end

endmodule

>>> tb/sv/tacrb_checker.sv
`timescale 1ns / 100ps
// Result checker for the touch and sound register block: predicts every result and compares it.
module tacrb_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tacrb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  tacrb_item_if                           item_i,
  tacrb_result_if                         result_i,
  output int unsigned                     errors_o,
  output int unsigned                     waiting_o,
  output int unsigned                     checked_o
);
  import tacrb_pkg::*;

  logic [15:0] period_q;
  logic [4:0]  scale_q;

  logic [15:0] adc_ctrl, adc_stat, codec_ctrl, codec_stat;
  logic [15:0] codec_data, sound_ctrl, sound_stat, irq_mask;
  logic [15:0] codec_file [CODEC_REGS];
  logic [11:0] x_sample, y_sample;
  logic        pen_is_down;
  logic        timing_on;
  logic [15:0] tick_count;

  result_t     expected_results [$];
  result_t     want, seen;
  item_t       req;
  int unsigned error_count = 0;
  int unsigned checked_count = 0;

  assign errors_o  = error_count;
  assign checked_o = checked_count;

  task automatic note_failure(input string what);
    if (error_count < 50) $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] exp_v);
    if (got !== exp_v)
      note_failure($sformatf("result %0d, %s: got %h, expected %h", checked_count, name, got,
                             exp_v));
  endtask

  function automatic logic [11:0] pixel_to_raw(logic signed [15:0] pix);
    logic [31:0] prod;
    if (pix < 0) return 12'd0;
    prod = {16'd0, pix} * {27'd0, scale_q};
    return (prod > {16'd0, SAMPLE_MASK}) ? SAMPLE_MASK[11:0] : prod[11:0];
  endfunction

  function automatic logic irq_level_now();
    return (|(adc_stat & irq_mask & ADC_CLR)) || (|(codec_stat & irq_mask & CODEC_CLR)) ||
           ((|(irq_mask & MASK_SOUND)) && (|(sound_stat & SOUND_CLR)));
  endfunction

  // Returns 1 when the write faults; a faulting write leaves every register as it was.
  function automatic logic apply_write(logic [7:0] off, logic [15:0] v, output logic flipped);
    logic [15:0]            entry;
    logic [CODEC_IDX_W-1:0] idx;
    flipped = 1'b0;
    case (off)
      OFF_ADC_CTRL: begin
        if ((|(v & TIMING_EN)) && !timing_on) tick_count = '0;
        timing_on = |(v & TIMING_EN);
        if (|(v & DO_SAMPLE)) begin
          adc_ctrl = (v & ~SAMPLE_MASK) | {4'd0, ((|(v & SEL_Y)) ? y_sample : x_sample)};
          adc_stat = adc_stat | ADC_PEN_BIT;
        end else begin
          adc_ctrl = v;
        end
      end
      OFF_ADC_STAT: begin
        if (|(v & ~ADC_CLR)) return 1'b1;
        adc_stat = adc_stat & ~v;
      end
      OFF_CODEC_CTRL: codec_ctrl = v;
      OFF_CODEC_STAT: begin
        if (|(v & ~CODEC_CLR)) return 1'b1;
        codec_stat = codec_stat & ~v;
      end
      OFF_CODEC_DATA: begin
        idx = codec_ctrl[CODEC_IDX_W-1:0];
        if (|(codec_ctrl & CODEC_WR)) begin
          codec_file[idx] = v;
          codec_data = v;
        end else begin
          // The calibration entry always reads as done, and the pen entry shows the pen state.
          entry = codec_file[idx];
          if (idx == CODEC_IDX_CAL) entry = entry | CAL_DONE_BITS;
          if (idx == CODEC_IDX_PEN) entry = pen_is_down ? (entry & ~PEN_UP_BIT)
                                                        : (entry | PEN_UP_BIT);
          codec_data = entry;
        end
        codec_stat = codec_stat | CODEC_DONE;
      end
      OFF_SOUND_CTRL: begin
        flipped = |((sound_ctrl ^ v) & PLAY_EN);
        sound_ctrl = v;
      end
      OFF_SOUND_STAT: begin
        if (|(v & ~SOUND_CLR)) return 1'b1;
        sound_stat = sound_stat & ~v;
      end
      OFF_IRQ_MASK: irq_mask = v;
      default: return 1'b1;
    endcase
    return 1'b0;
  endfunction

  function automatic result_t step_registers(item_t it);
    result_t     r;
    logic        flipped;
    logic [16:0] next_count;
    r = '0;
    case (it.mode)
      MODE_READ: begin
        case (it.reg_offset)
          OFF_ADC_CTRL:   r.read_data = adc_ctrl;
          OFF_ADC_STAT:   r.read_data = adc_stat;
          OFF_CODEC_CTRL: r.read_data = codec_ctrl;
          OFF_CODEC_STAT: r.read_data = codec_stat;
          OFF_CODEC_DATA: r.read_data = codec_data;
          OFF_SOUND_CTRL: r.read_data = sound_ctrl;
          OFF_SOUND_STAT: r.read_data = sound_stat;
          OFF_IRQ_MASK:   r.read_data = irq_mask;
          default:        r.fault = 1'b1;
        endcase
      end
      MODE_WRITE: begin
        if (|it.write_data[31:16]) begin
          r.fault = 1'b1;
        end else begin
          r.fault = apply_write(it.reg_offset, it.write_data[15:0], flipped);
          r.playback_changed = flipped;
        end
      end
      MODE_DOWN: begin
        x_sample = pixel_to_raw(it.pen_x);
        y_sample = pixel_to_raw(it.pen_y);
        adc_stat = adc_stat | ADC_DOWN_BIT;
        pen_is_down = 1'b1;
      end
      MODE_MOVE: begin
        if (pen_is_down) begin
          x_sample = pixel_to_raw(it.pen_x);
          y_sample = pixel_to_raw(it.pen_y);
        end
      end
      MODE_UP: pen_is_down = 1'b0;
      MODE_TICK: begin
        if (timing_on) begin
          next_count = {1'b0, tick_count} + 17'd1;
          // A period of zero behaves as one, which this compare gives for free.
          if (next_count >= {1'b0, period_q}) begin
            tick_count = '0;
            adc_stat = adc_stat | ADC_TIME_BIT;
          end else begin
            tick_count = next_count[15:0];
          end
        end
      end
      MODE_RAISE: begin
        r.sound_already_set = |(sound_stat & it.raise_bits);
        sound_stat = sound_stat | it.raise_bits;
      end
      default: ;
    endcase
    r.irq = irq_level_now();
    r.playback_enable = |(sound_ctrl & PLAY_EN);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q = PEN_PERIOD_RST;
      scale_q = COORD_SCALE_RST;
      adc_ctrl = '0;
      adc_stat = '0;
      codec_ctrl = '0;
      codec_stat = '0;
      codec_data = '0;
      sound_ctrl = '0;
      sound_stat = '0;
      irq_mask = '0;
      for (int i = 0; i < CODEC_REGS; i++) codec_file[i] = '0;
      x_sample = '0;
      y_sample = '0;
      pen_is_down = 1'b0;
      timing_on = 1'b0;
      tick_count = '0;
      expected_results.delete();
      waiting_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PEN_PERIOD:  period_q = cfg_data_i;
          CFG_COORD_SCALE: scale_q = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (item_i.valid && item_i.ready) begin
        req.mode = item_i.mode;
        req.reg_offset = item_i.reg_offset;
        req.write_data = item_i.write_data;
        req.pen_x = item_i.pen_x;
        req.pen_y = item_i.pen_y;
        req.raise_bits = item_i.raise_bits;
        expected_results.push_back(step_registers(req));
      end
      if (result_i.valid && result_i.ready) begin
        seen.read_data = result_i.read_data;
        seen.irq = result_i.irq;
        seen.fault = result_i.fault;
        seen.playback_enable = result_i.playback_enable;
        seen.playback_changed = result_i.playback_changed;
        seen.sound_already_set = result_i.sound_already_set;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result %0d arrived with no request waiting", checked_count));
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", seen.read_data, want.read_data);
          check_field("irq", 16'(seen.irq), 16'(want.irq));
          check_field("fault", 16'(seen.fault), 16'(want.fault));
          check_field("playback_enable", 16'(seen.playback_enable), 16'(want.playback_enable));
          check_field("playback_changed", 16'(seen.playback_changed),
                      16'(want.playback_changed));
          check_field("sound_already_set", 16'(seen.sound_already_set),
                      16'(want.sound_already_set));
        end
        checked_count++;
      end
      waiting_o <= expected_results.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the touch and sound register block: stimulus, idling and the verdict.
module testbench;
  import tacrb_pkg::*;

  localparam int unsigned PHASES      = 5;
  localparam int unsigned PER_PHASE   = 250;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef enum int {
    SEQ_READ, SEQ_WRITE, SEQ_CODEC, SEQ_PEN, SEQ_TIMING, SEQ_SOUND, SEQ_MASK, SEQ_NOISE,
    SEQ_TICKS, SEQ_LIFT, SEQ_COUNT
  } seq_kind_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 quiet;

  int unsigned errors, waiting, checked;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned setting_count = 1;

  tacrb_item_if   req_if ();
  tacrb_result_if res_if ();

  touch_audio_codec_register_block uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .item_i      (req_if),
    .result_o    (res_if)
  );

  tacrb_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .item_i      (req_if),
    .result_i    (res_if),
    .errors_o    (errors),
    .waiting_o   (waiting),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The result side stalls in random bursts, except in the quiet final phase.
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  task automatic send(input logic [2:0] mode, input logic [7:0] off, input logic [31:0] wd,
                      input logic signed [15:0] px, input logic signed [15:0] py,
                      input logic [15:0] rb);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= mode;
    req_if.reg_offset <= off;
    req_if.write_data <= wd;
    req_if.pen_x <= px;
    req_if.pen_y <= py;
    req_if.raise_bits <= rb;
    do @(posedge clk_i); while (!req_if.ready);
    sent_count++;
  endtask

  task automatic rd(input logic [7:0] off);
    send(MODE_READ, off, 32'd0, 16'sd0, 16'sd0, 16'd0);
  endtask

  task automatic wr(input logic [7:0] off, input logic [15:0] v);
    send(MODE_WRITE, off, {16'd0, v}, 16'sd0, 16'sd0, 16'd0);
  endtask

  task automatic pen(input logic [2:0] mode, input logic signed [15:0] px,
                     input logic signed [15:0] py);
    send(mode, OFF_ADC_CTRL, 32'd0, px, py, 16'd0);
  endtask

  task automatic tick();
    send(MODE_TICK, OFF_ADC_CTRL, 32'd0, 16'sd0, 16'sd0, 16'd0);
  endtask

  task automatic raise(input logic [15:0] bits);
    send(MODE_RAISE, OFF_ADC_CTRL, 32'd0, 16'sd0, 16'sd0, bits);
  endtask

  // Hold requests back until every result is in, then let the block settle.
  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (waiting != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_offset();
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    return 8'(4 * $urandom_range(0, 7));
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'(0 - $urandom_range(1, 300));
      default: return 16'($urandom_range(0, 1100));
    endcase
  endfunction

  // Status registers mostly get values inside their clear mask.
  function automatic logic [15:0] write_value_for(logic [7:0] off);
    logic [15:0] v;
    v = 16'($urandom);
    if ($urandom_range(0, 7) == 0) return v;
    case (off)
      OFF_ADC_STAT:   return v & ADC_CLR;
      OFF_CODEC_STAT: return v & CODEC_CLR;
      OFF_SOUND_STAT: return v & SOUND_CLR;
      default:        return v;
    endcase
  endfunction

  task automatic random_write();
    logic [7:0]  off;
    logic [15:0] v;
    off = rand_offset();
    v = write_value_for(off);
    if ($urandom_range(0, 11) == 0)
      send(MODE_WRITE, off, {16'($urandom_range(1, 65535)), v}, 16'sd0, 16'sd0, 16'd0);
    else
      wr(off, v);
  endtask

  task automatic directed_requests();
    rd(8'h20);
    rd(8'hFF);
    wr(OFF_IRQ_MASK, 16'h001F);
    send(MODE_WRITE, OFF_IRQ_MASK, 32'hFFFF_0000, 16'sd0, 16'sd0, 16'd0);
    pen(MODE_MOVE, 16'sd100, 16'sd100);
    pen(MODE_DOWN, -16'sd32768, 16'sd32767);
    wr(OFF_ADC_CTRL, DO_SAMPLE);
    wr(OFF_ADC_CTRL, DO_SAMPLE | SEL_Y | SAMPLE_MASK);
    rd(OFF_ADC_CTRL);
    wr(OFF_ADC_STAT, 16'h0020);
    wr(OFF_ADC_STAT, ADC_CLR);
    wr(OFF_CODEC_CTRL, CODEC_WR | 16'(CODEC_IDX_CAL));
    wr(OFF_CODEC_DATA, 16'h0000);
    wr(OFF_CODEC_CTRL, 16'(CODEC_IDX_CAL));
    wr(OFF_CODEC_DATA, 16'hFFFF);
    wr(OFF_CODEC_CTRL, 16'(CODEC_IDX_PEN));
    wr(OFF_CODEC_DATA, 16'h0000);
    pen(MODE_UP, 16'sd0, 16'sd0);
    wr(OFF_CODEC_DATA, 16'h0000);
    wr(OFF_CODEC_STAT, 16'h0002);
    wr(OFF_CODEC_STAT, CODEC_DONE);
    wr(OFF_SOUND_CTRL, PLAY_EN);
    wr(OFF_SOUND_CTRL, 16'hBFFF);
    raise(16'hF00F);
    raise(16'h1000);
    wr(OFF_SOUND_STAT, 16'h0F00);
    wr(OFF_SOUND_STAT, SOUND_CLR);
    wr(OFF_ADC_CTRL, TIMING_EN);
    repeat (5) tick();
    rd(OFF_ADC_STAT);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned start;
    logic [15:0] v;
    start = sent_count;
    while (sent_count - start < count) begin
      case (seq_kind_e'($urandom_range(0, SEQ_COUNT - 1)))
        SEQ_READ: rd(rand_offset());
        SEQ_WRITE: random_write();
        SEQ_CODEC: begin
          v = 16'($urandom_range(0, CODEC_REGS - 1));
          if ($urandom_range(0, 1) == 0) v = v | CODEC_WR;
          if ($urandom_range(0, 3) == 0) v = v | (16'($urandom) & 16'hFFE0);
          wr(OFF_CODEC_CTRL, v);
          wr(OFF_CODEC_DATA, 16'($urandom));
          rd(OFF_CODEC_DATA);
          rd(OFF_CODEC_STAT);
          wr(OFF_CODEC_STAT, CODEC_DONE);
        end
        SEQ_PEN: begin
          pen(MODE_DOWN, rand_coord(), rand_coord());
          repeat ($urandom_range(0, 3)) pen(MODE_MOVE, rand_coord(), rand_coord());
          v = DO_SAMPLE | (16'($urandom) & (SEL_Y | TIMING_EN | 16'hB3FF));
          wr(OFF_ADC_CTRL, v);
          rd(OFF_ADC_CTRL);
          rd(OFF_ADC_STAT);
          if ($urandom_range(0, 1) == 0) pen(MODE_UP, rand_coord(), rand_coord());
        end
        SEQ_TIMING: begin
          v = 16'($urandom) & ~DO_SAMPLE;
          if ($urandom_range(0, 2) != 0) v = v | TIMING_EN;
          wr(OFF_ADC_CTRL, v);
          repeat ($urandom_range(1, 8)) tick();
          rd(OFF_ADC_STAT);
          wr(OFF_ADC_STAT, 16'($urandom) & ADC_CLR);
        end
        SEQ_SOUND: begin
          raise(($urandom_range(0, 2) == 0) ? 16'($urandom) : (16'($urandom) & SOUND_CLR));
          wr(OFF_SOUND_CTRL, 16'($urandom));
          rd(OFF_SOUND_STAT);
          wr(OFF_SOUND_STAT, 16'($urandom) & SOUND_CLR);
        end
        SEQ_MASK: begin
          wr(OFF_IRQ_MASK, 16'($urandom));
          rd(OFF_IRQ_MASK);
        end
        SEQ_NOISE: send(3'($urandom_range(MODE_READ, MODE_RAISE)), 8'($urandom), $urandom,
                        16'($urandom), 16'($urandom), 16'($urandom));
        SEQ_TICKS: repeat ($urandom_range(1, 6)) tick();
        default: pen(($urandom_range(0, 1) == 0) ? MODE_UP : MODE_MOVE, rand_coord(),
                     rand_coord());
      endcase
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PEN_PERIOD;
    cfg_data <= '0;
    quiet <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.mode <= MODE_READ;
    req_if.reg_offset <= OFF_ADC_CTRL;
    req_if.write_data <= '0;
    req_if.pen_x <= '0;
    req_if.pen_y <= '0;
    req_if.raise_bits <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The directed requests run with the reset values of period and scale.
    directed_requests();

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          set_config(CFG_PEN_PERIOD, 16'd1);
          set_config(CFG_COORD_SCALE, 16'd16);
        end
        1: begin
          set_config(CFG_PEN_PERIOD, 16'd65535);
          set_config(CFG_COORD_SCALE, 16'd1);
        end
        2: begin
          set_config(CFG_PEN_PERIOD, 16'd3);
          set_config(CFG_COORD_SCALE, 16'd5);
        end
        default: begin
          set_config(CFG_PEN_PERIOD, 16'($urandom_range(2, 9)));
          set_config(CFG_COORD_SCALE, 16'($urandom_range(1, 16)));
        end
      endcase
      setting_count++;
      if (p == PHASES - 1) quiet <= 1'b1;
      random_phase(PER_PHASE);
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d requests under %0d period and scale settings, reset values included;",
             sent_count, setting_count);
    $display("%0d results were compared field by field.", checked);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
